// ===== design/oss_pkg.sv =====
// Shared control types and request codes for the ordered sequence store.
package oss_pkg;

   typedef enum logic [2:0] {
      OP_INSERT_AT     = 3'd0,
      OP_INSERT_SORTED = 3'd1,
      OP_ERASE         = 3'd2,
      OP_REMOVE_ALL    = 3'd3,
      OP_GET           = 3'd4,
      OP_SET           = 3'd5,
      OP_FIND          = 3'd6,
      OP_UNUSED        = 3'd7
   } op_type;

   // Per-cycle command broadcast from the sequencer to every cell
   typedef struct packed {
      logic load;     // capture compare flags, hole marks and readout copy
      logic cmp_gt;   // flag compares greater-than instead of equal
      logic shift;    // move flag and readout one cell toward the head
      logic bubble;   // run one odd-even exchange phase on hole marks
      logic phase;    // parity of the lower cell in each exchange pair
      logic ins;      // open a slot at the target and write the value
      logic del;      // close the slot at the target
      logic wr;       // overwrite the target entry
   } ctl_type;

endpackage

// ===== design/oss_cell.sv =====
// One storage cell of the sequence chain: entry, hole mark, scan flag and readout.
module oss_cell #(
   parameter int VALUE_WIDTH = 32,
   parameter int CW = 5,
   parameter int XW = 5,
   parameter int IDX = 0
) (
   input  logic                   clock,
   input  oss_pkg::ctl_type       ctl,
   input  logic [CW-1:0]          count,
   input  logic [XW-1:0]          tgt,
   input  logic [VALUE_WIDTH-1:0] val,
   input  logic [VALUE_WIDTH-1:0] below_data,
   input  logic                   below_hole,
   input  logic [VALUE_WIDTH-1:0] above_data,
   input  logic                   above_hole,
   input  logic                   above_flag,
   input  logic [VALUE_WIDTH-1:0] above_rd,
   output logic [VALUE_WIDTH-1:0] data,
   output logic                   hole,
   output logic                   flag,
   output logic [VALUE_WIDTH-1:0] rd
);
   import oss_pkg::*;

   localparam logic [XW-1:0] MY_IDX = XW'(IDX);
   localparam logic PAR = 1'(IDX % 2);

   logic [VALUE_WIDTH-1:0] data_ff, data_in;
   logic [VALUE_WIDTH-1:0] rd_ff, rd_in;
   logic                   hole_ff, hole_in;
   logic                   flag_ff, flag_in;
   logic                   valid;
   logic                   eq;
   logic                   gt;

   assign valid = MY_IDX < XW'(count);
   assign eq    = data_ff == val;
   assign gt    = data_ff > val;

   always_comb begin
      data_in = data_ff;
      hole_in = hole_ff;
      flag_in = flag_ff;
      rd_in   = rd_ff;
      if (ctl.load) begin
         flag_in = valid && (ctl.cmp_gt ? gt : eq);
         hole_in = !valid || eq;
         rd_in   = data_ff;
      end
      if (ctl.shift) begin
         flag_in = above_flag;
         rd_in   = above_rd;
      end
      if (ctl.bubble) begin
         // lower cell of a pair pulls a kept entry down over a hole
         if ((PAR == ctl.phase) && hole_ff && !above_hole) begin
            data_in = above_data;
            hole_in = 1'b0;
         end else if ((PAR != ctl.phase) && below_hole && !hole_ff) begin
            data_in = below_data;
            hole_in = 1'b1;
         end
      end
      if (ctl.ins) begin
         if (MY_IDX > tgt) begin
            data_in = below_data;
         end else if (MY_IDX == tgt) begin
            data_in = val;
         end
      end
      if (ctl.del && (MY_IDX >= tgt)) begin
         data_in = above_data;
      end
      if (ctl.wr && (MY_IDX == tgt)) begin
         data_in = val;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      hole_ff <= hole_in;
      flag_ff <= flag_in;
      rd_ff   <= rd_in;
   end

   assign data = data_ff;
   assign hole = hole_ff;
   assign flag = flag_ff;
   assign rd   = rd_ff;

endmodule

// ===== design/ordered_sequence_store.sv =====
// Top level of the ordered sequence store: request sequencer over a chain of cells.
//
//   channel   | handshake                 | payload
//   ----------+---------------------------+------------------------------------------
//   request   | start, busy               | req_type, req_position, req_item_value
//   result    | rsp_strobe (one cycle)    | rsp_ok, rsp_result_index, rsp_result_value,
//             |                           | rsp_removed_count, rsp_entry_count
//
// insert_at, erase, set, requests rejected at once and the unused code: result in the next
// cycle, busy stays low, so one request per cycle.
// get scans up to its position; insert_sorted, remove_all and find scan all entries;
// busy is high meanwhile and the result shows as busy falls. The scan is paced by the flag
// and readout chain, which moves one cell toward the head per cycle.
// Reset clears the entry count and the sequencer; entry contents stay undefined.
// Results cannot be held off; each is shown for exactly one cycle.
module ordered_sequence_store #(
   parameter int CAPACITY = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_type,
   input  logic [4:0]  req_position,
   input  logic [31:0] req_item_value,
   output logic        rsp_strobe,
   output logic        rsp_ok,
   output logic [4:0]  rsp_result_index,
   output logic [31:0] rsp_result_value,
   output logic [4:0]  rsp_removed_count,
   output logic [4:0]  rsp_entry_count
);
   import oss_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > 5) ? CW : 5;
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic                   state_ff, state_in;
   logic [2:0]             op_ff, op_in;
   logic [4:0]             pos_ff, pos_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          t_ff, t_in;
   logic                   found_ff, found_in;
   logic [CW-1:0]          first_ff, first_in;
   logic [CW-1:0]          cnt_ff, cnt_in;

   logic        rsp_strobe_ff, rsp_strobe_in;
   logic        rsp_ok_ff, rsp_ok_in;
   logic [4:0]  rsp_index_ff, rsp_index_in;
   logic [31:0] rsp_value_ff, rsp_value_in;
   logic [4:0]  rsp_removed_ff, rsp_removed_in;
   logic [4:0]  rsp_count_ff, rsp_count_in;

   logic [63:0]            item_wide;
   logic [VALUE_WIDTH-1:0] item_val;
   logic [VALUE_WIDTH-1:0] val_bus;
   logic [XW-1:0]          tgt;
   logic [XW-1:0]          pos_x;
   logic [XW-1:0]          cnt_x;
   logic [XW-1:0]          idx_x;
   logic [XW-1:0]          removed_x;
   logic [XW-1:0]          entries_x;
   logic [63:0]            rd_wide;
   logic                   accept;
   ctl_type                ctl;

   logic [VALUE_WIDTH-1:0] data_w [CAPACITY];
   logic [VALUE_WIDTH-1:0] rd_w   [CAPACITY];
   logic                   hole_w [CAPACITY];
   logic                   flag_w [CAPACITY];

   assign item_wide = 64'(req_item_value);
   assign item_val  = item_wide[VALUE_WIDTH-1:0];
   assign rd_wide   = 64'(rd_w[0]);
   assign busy      = state_ff == ST_SCAN;
   assign accept    = start && !busy;
   assign val_bus   = busy ? val_ff : item_val;
   assign cnt_x     = XW'(count_ff);

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      pos_in         = pos_ff;
      val_in         = val_ff;
      count_in       = count_ff;
      t_in           = t_ff;
      found_in       = found_ff;
      first_in       = first_ff;
      cnt_in         = cnt_ff;
      ctl            = '0;
      tgt            = XW'(req_position);
      pos_x          = XW'(req_position);
      idx_x          = '0;
      removed_x      = '0;
      rsp_strobe_in  = 1'b0;
      rsp_ok_in      = 1'b0;
      rsp_value_in   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_type;
               pos_in   = req_position;
               val_in   = item_val;
               t_in     = '0;
               found_in = 1'b0;
               first_in = '0;
               cnt_in   = '0;
               rsp_strobe_in = 1'b1;
               case (req_type)
                  OP_INSERT_AT: begin
                     if ((pos_x <= cnt_x) && (count_ff < CAP_C)) begin
                        ctl.ins   = 1'b1;
                        count_in  = count_ff + 1'b1;
                        rsp_ok_in = 1'b1;
                        idx_x     = pos_x;
                     end
                  end
                  OP_INSERT_SORTED: begin
                     if (count_ff < CAP_C) begin
                        ctl.load      = 1'b1;
                        ctl.cmp_gt    = 1'b1;
                        state_in      = ST_SCAN;
                        rsp_strobe_in = 1'b0;
                     end
                  end
                  OP_ERASE: begin
                     if (pos_x < cnt_x) begin
                        ctl.del   = 1'b1;
                        count_in  = count_ff - 1'b1;
                        rsp_ok_in = 1'b1;
                     end
                  end
                  OP_REMOVE_ALL, OP_FIND: begin
                     ctl.load      = 1'b1;
                     state_in      = ST_SCAN;
                     rsp_strobe_in = 1'b0;
                  end
                  OP_GET: begin
                     if (pos_x < cnt_x) begin
                        ctl.load      = 1'b1;
                        state_in      = ST_SCAN;
                        rsp_strobe_in = 1'b0;
                     end
                  end
                  OP_SET: begin
                     if (pos_x < cnt_x) begin
                        ctl.wr    = 1'b1;
                        rsp_ok_in = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            pos_x      = XW'(pos_ff);
            ctl.shift  = 1'b1;
            ctl.bubble = op_ff == OP_REMOVE_ALL;
            ctl.phase  = t_ff[0];
            t_in       = t_ff + 1'b1;
            cnt_in     = cnt_ff + CW'(flag_w[0]);
            if (flag_w[0] && !found_ff) begin
               found_in = 1'b1;
               first_in = t_ff;
            end
            tgt = found_ff ? XW'(first_ff) : cnt_x;
            if ((op_ff == OP_GET) ? (XW'(t_ff) == pos_x) : (t_ff == count_ff)) begin
               state_in      = ST_IDLE;
               rsp_strobe_in = 1'b1;
               case (op_ff)
                  OP_INSERT_SORTED: begin
                     ctl.ins   = 1'b1;
                     count_in  = count_ff + 1'b1;
                     rsp_ok_in = 1'b1;
                     idx_x     = tgt;
                  end
                  OP_REMOVE_ALL: begin
                     count_in  = count_ff - cnt_ff;
                     rsp_ok_in = 1'b1;
                     removed_x = XW'(cnt_ff);
                  end
                  OP_GET: begin
                     rsp_ok_in    = 1'b1;
                     rsp_value_in = rd_wide[31:0];
                  end
                  OP_FIND: begin
                     rsp_ok_in = found_ff;
                     idx_x     = found_ff ? XW'(first_ff) : '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      entries_x      = XW'(count_in);
      rsp_index_in   = idx_x[4:0];
      rsp_removed_in = removed_x[4:0];
      rsp_count_in   = entries_x[4:0];
   end

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic [VALUE_WIDTH-1:0] below_data;
         logic                   below_hole;
         logic [VALUE_WIDTH-1:0] above_data;
         logic                   above_hole;
         logic                   above_flag;
         logic [VALUE_WIDTH-1:0] above_rd;

         if (gi == 0) begin : g_head
            assign below_data = '0;
            assign below_hole = 1'b0;
         end else begin : g_mid_lo
            assign below_data = data_w[gi-1];
            assign below_hole = hole_w[gi-1];
         end

         if (gi == CAPACITY - 1) begin : g_tail
            assign above_data = '0;
            assign above_hole = 1'b1;
            assign above_flag = 1'b0;
            assign above_rd   = '0;
         end else begin : g_mid_hi
            assign above_data = data_w[gi+1];
            assign above_hole = hole_w[gi+1];
            assign above_flag = flag_w[gi+1];
            assign above_rd   = rd_w[gi+1];
         end

         oss_cell #(
            .VALUE_WIDTH(VALUE_WIDTH),
            .CW(CW),
            .XW(XW),
            .IDX(gi)
         ) u_cell (
            .clock(clock),
            .ctl(ctl),
            .count(count_ff),
            .tgt(tgt),
            .val(val_bus),
            .below_data(below_data),
            .below_hole(below_hole),
            .above_data(above_data),
            .above_hole(above_hole),
            .above_flag(above_flag),
            .above_rd(above_rd),
            .data(data_w[gi]),
            .hole(hole_w[gi]),
            .flag(flag_w[gi]),
            .rd(rd_w[gi])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      pos_ff         <= pos_in;
      val_ff         <= val_in;
      t_ff           <= t_in;
      found_ff       <= found_in;
      first_ff       <= first_in;
      cnt_ff         <= cnt_in;
      rsp_ok_ff      <= rsp_ok_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_ok            = rsp_ok_ff;
   assign rsp_result_index  = rsp_index_ff;
   assign rsp_result_value  = rsp_value_ff;
   assign rsp_removed_count = rsp_removed_ff;
   assign rsp_entry_count   = rsp_count_ff;

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the ordered sequence store: directed edges, random traffic.
module tb;
   import oss_pkg::*;

   localparam int CAPACITY = 16;
   localparam int WATCHDOG_LIMIT = 1000;

   typedef struct {
      logic        ok;
      logic [4:0]  index;
      logic [31:0] value;
      logic [4:0]  removed;
      logic [4:0]  count;
   } list_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_type = 3'd0;
   logic [4:0]  req_position = 5'd0;
   logic [31:0] req_item_value = 32'd0;
   logic        rsp_strobe;
   logic        rsp_ok;
   logic [4:0]  rsp_result_index;
   logic [31:0] rsp_result_value;
   logic [4:0]  rsp_removed_count;
   logic [4:0]  rsp_entry_count;

   ordered_sequence_store dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_position      (req_position),
      .req_item_value    (req_item_value),
      .rsp_strobe        (rsp_strobe),
      .rsp_ok            (rsp_ok),
      .rsp_result_index  (rsp_result_index),
      .rsp_result_value  (rsp_result_value),
      .rsp_removed_count (rsp_removed_count),
      .rsp_entry_count   (rsp_entry_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Shadow copy of the list, updated in request order
   bit [31:0]       shadow_entries [CAPACITY];
   int              shadow_count = 0;
   list_result_type awaited_results [$];
   int              mismatch_count = 0;
   int              quiet_cycles = 0;
   bit              pacing = 1'b0;
   int              burst_left = 0;
   bit [31:0]       value_pool [6];

   function automatic list_result_type apply_list_op(op_type op, bit [4:0] pos,
                                                     bit [31:0] val);
      list_result_type res;
      int i;
      int at;
      int keep;
      res = '{ok: 1'b0, index: 5'd0, value: 32'd0, removed: 5'd0, count: 5'd0};
      case (op)
         OP_INSERT_AT: begin
            if (pos <= shadow_count && shadow_count < CAPACITY) begin
               for (i = shadow_count; i > pos; i--) shadow_entries[i] = shadow_entries[i-1];
               shadow_entries[pos] = val;
               shadow_count++;
               res.ok = 1'b1;
               res.index = pos;
            end
         end
         OP_INSERT_SORTED: begin
            if (shadow_count < CAPACITY) begin
               at = shadow_count;
               // land after equal values: first strictly greater entry wins
               for (i = shadow_count - 1; i >= 0; i--)
                  if (shadow_entries[i] > val) at = i;
               for (i = shadow_count; i > at; i--) shadow_entries[i] = shadow_entries[i-1];
               shadow_entries[at] = val;
               shadow_count++;
               res.ok = 1'b1;
               res.index = at[4:0];
            end
         end
         OP_ERASE: begin
            if (pos < shadow_count) begin
               for (i = pos; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i+1];
               shadow_count--;
               res.ok = 1'b1;
            end
         end
         OP_REMOVE_ALL: begin
            keep = 0;
            for (i = 0; i < shadow_count; i++) begin
               if (shadow_entries[i] == val) begin
                  res.removed++;
               end else begin
                  shadow_entries[keep] = shadow_entries[i];
                  keep++;
               end
            end
            shadow_count = keep;
            res.ok = 1'b1;
         end
         OP_GET: begin
            if (pos < shadow_count) begin
               res.value = shadow_entries[pos];
               res.ok = 1'b1;
            end
         end
         OP_SET: begin
            if (pos < shadow_count) begin
               shadow_entries[pos] = val;
               res.ok = 1'b1;
            end
         end
         OP_FIND: begin
            for (i = 0; i < shadow_count; i++) begin
               if (!res.ok && shadow_entries[i] == val) begin
                  res.ok = 1'b1;
                  res.index = i[4:0];
               end
            end
         end
         default: ;
      endcase
      res.count = shadow_count[4:0];
      return res;
   endfunction

   function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
      if (act !== exp) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, exp, act);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      list_result_type exp;
      if (!reset && rsp_strobe) begin
         if (awaited_results.size() == 0) begin
            $display("%0t: result with none awaited, expected nothing, got ok=%0b count=%0d",
                     $time, rsp_ok, rsp_entry_count);
            mismatch_count++;
         end else begin
            exp = awaited_results.pop_front();
            check_field("ok", 32'(exp.ok), 32'(rsp_ok));
            check_field("result_index", 32'(exp.index), 32'(rsp_result_index));
            check_field("result_value", exp.value, rsp_result_value);
            check_field("removed_count", 32'(exp.removed), 32'(rsp_removed_count));
            check_field("entry_count", 32'(exp.count), 32'(rsp_entry_count));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // Idle between bursts of random length
   task automatic pace();
      if (!pacing) return;
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
         burst_left = $urandom_range(0, 20);
      end else begin
         burst_left--;
      end
   endtask

   task automatic send_request(op_type op, bit [4:0] pos, bit [31:0] val);
      start <= 1'b1;
      req_type <= op;
      req_position <= pos;
      req_item_value <= val;
      do @(posedge clock); while (busy);
      awaited_results.push_back(apply_list_op(op, pos, val));
      pace();
   endtask

   // Hold off new requests until every result is in
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   function automatic op_type pick_op(int ins_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < ins_pct) return ($urandom_range(0, 1) != 0) ? OP_INSERT_SORTED : OP_INSERT_AT;
      r = $urandom_range(0, 99);
      if (r < 18) return OP_ERASE;
      if (r < 30) return OP_REMOVE_ALL;
      if (r < 50) return OP_GET;
      if (r < 68) return OP_SET;
      if (r < 94) return OP_FIND;
      return OP_UNUSED;
   endfunction

   function automatic bit [4:0] pick_position();
      if ($urandom_range(0, 99) < 80) return 5'($urandom_range(0, shadow_count));
      return 5'($urandom_range(0, 31));
   endfunction

   function automatic bit [31:0] pick_value();
      if ($urandom_range(0, 99) < 65) return value_pool[$urandom_range(0, 5)];
      return $urandom();
   endfunction

   task automatic test_empty_and_full_edges();
      pacing = 1'b0;
      send_request(OP_FIND, 5'd0, 32'd0);
      send_request(OP_REMOVE_ALL, 5'd0, 32'd0);
      send_request(OP_GET, 5'd0, 32'd0);
      send_request(OP_ERASE, 5'd0, 32'd0);
      send_request(OP_INSERT_AT, 5'd31, 32'h1234_5678);
      send_request(OP_UNUSED, 5'd31, 32'hFFFF_FFFF);
      send_request(OP_INSERT_AT, 5'd0, 32'hFFFF_FFFF);
      send_request(OP_INSERT_AT, 5'd1, 32'd0);
      // pairs of equal values exercise placement after equals
      for (int k = 0; k < 14; k++)
         send_request(OP_INSERT_SORTED, 5'd0, 32'h8000_0000 >> (k >> 1));
      send_request(OP_INSERT_AT, 5'd16, 32'd9);
      send_request(OP_INSERT_SORTED, 5'd0, 32'd9);
      send_request(OP_GET, 5'd16, 32'd0);
      send_request(OP_SET, 5'd16, 32'd1);
      send_request(OP_GET, 5'd15, 32'd0);
      send_request(OP_FIND, 5'd0, 32'h0400_0000);
      send_request(OP_REMOVE_ALL, 5'd0, 32'h0400_0000);
      send_request(OP_ERASE, 5'd13, 32'd0);
      send_request(OP_SET, 5'd0, 32'h5A5A_A5A5);
      send_request(OP_FIND, 5'd0, 32'h7777_7777);
   endtask

   task automatic test_random_mix(int n, int ins_pct);
      pacing = 1'b1;
      for (int k = 0; k < n; k++) begin
         if (k % 100 == 0) value_pool[5] = $urandom();
         send_request(pick_op(ins_pct), pick_position(), pick_value());
      end
   endtask

   task automatic test_back_to_back(int n);
      pacing = 1'b0;
      for (int k = 0; k < n; k++)
         send_request(pick_op(45), pick_position(), pick_value());
   endtask

   task automatic test_drain_pauses(int n);
      pacing = 1'b1;
      for (int k = 0; k < n; k++) begin
         send_request(pick_op(50), pick_position(), pick_value());
         if (k % 40 == 39) drain();
      end
   endtask

   initial begin
      value_pool[0] = 32'd0;
      value_pool[1] = 32'hFFFF_FFFF;
      value_pool[2] = 32'h8000_0000;
      value_pool[3] = 32'h7FFF_FFFF;
      value_pool[4] = $urandom();
      value_pool[5] = $urandom();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_empty_and_full_edges();
      test_random_mix(300, 55);
      test_random_mix(200, 25);
      test_back_to_back(330);
      test_drain_pauses(240);
      drain();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
